// ----- rtl/cbts_pkg.sv -----
// ---------------------------------------------------------------------------
// CAN bit timing search - shared package
// Sequencer states, search status, field widths and the timing word packer.
// ---------------------------------------------------------------------------
`default_nettype none

package cbts_pkg;

    // Field widths of the stream items.
    localparam int unsigned BaudW     = 32;
    localparam int unsigned ClockW    = 32;
    localparam int unsigned PrescW    = 4;
    localparam int unsigned WordW     = 15;
    localparam int unsigned OutDataW  = 24;

    // Search ranges: divider index 0..15, quanta index 0..31 (quanta - 1),
    // segment index 0..14 (segments - 3).
    localparam logic [3:0] DivLast    = 4'd15;
    localparam logic [4:0] QuantaLast = 5'd31;
    localparam logic [3:0] SegsLast   = 4'd14;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_OUT
    } cbts_state_t;

    // Status that the search unit reports to the sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } search_stat_t;

    // Pack the bit timing word from quanta - 1 and segments - 3.
    function automatic logic [WordW-1:0] pack_timing(input logic [4:0] q_idx,
                                                     input logic [3:0] s_idx);
        logic [2:0] t1;
        logic [3:0] t2;
        logic [1:0] sjw;
        t1  = s_idx[3:1];
        t2  = s_idx - {1'b0, t1};
        sjw = (t1 > 3'd3) ? 2'd3 : t1[1:0];
        return {t2[2:0], 1'b0, t1, sjw, 1'b0, q_idx};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/can_bit_timing_search_top.sv -----
// ---------------------------------------------------------------------------
// CAN bit timing search - top level
// Divides the main clock by the requested bit rate and searches for the
// first exact divider / quanta / segment split of the clocks per bit.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid / s_tready  s_tdata[31:0] = req_bit_rate
//  m_       out  m_tvalid / m_tready  m_tdata[0] found, [4:1] prescaler,
//                                     [19:5] bit_timing_word, [23:20] zero
//  cfg_     in   cfg_valid/cfg_ready  cfg_data[31:0] = main_clock_hz
//
//  The divider is launched in the cycle after an item is taken and runs to
//  completion; the search then loads and walks the candidates (up to 7680),
//  and the result waits in the ST_OUT state until the output register is
//  free. A zero bit rate skips the divider and the search.
//  s_tready is high only while the sequencer is idle; one result may wait
//  in the output register while the next item is being worked on.
//  Reset sets main_clock_hz to 48000000 and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module can_bit_timing_search_top
    import cbts_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BaudW-1:0]    s_tdata,    // [31:0] req_bit_rate
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutDataW-1:0]      m_tdata,    // [0] found, [4:1] prescaler,
                                                 // [19:5] bit_timing_word
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [ClockW-1:0]   cfg_data    // [31:0] main_clock_hz
);

    cbts_state_t           state_reg, state_next;
    logic [ClockW-1:0]     clk_hz_reg;
    logic [BaudW-1:0]      baud_reg;
    logic                  zero_reg, zero_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OutDataW-1:0]   m_tdata_reg,  m_tdata_next;
    logic                  div_start, div_done;
    logic [ClockW-1:0]     quotient;
    logic                  srch_start;
    search_stat_t          srch_stat;
    logic [PrescW-1:0]     srch_presc;
    logic [WordW-1:0]      srch_word;
    logic                  accept;
    // Divider launch strobe, high in the cycle after the item is taken.
    logic                  launch_reg;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Divider: clocks per bit.
    cbts_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (clk_hz_reg),
        .divisor  (baud_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Candidate walker with the shared compare.
    cbts_search u_srch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (srch_start),
        .cpb             (quotient),
        .stat            (srch_stat),
        .prescaler       (srch_presc),
        .bit_timing_word (srch_word)
    );

    // Sequencer: next state and strobes.
    always_comb begin
        state_next    = state_reg;
        zero_next     = zero_reg;
        s_tready      = 1'b0;
        div_start     = 1'b0;
        srch_start    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    zero_next  = (s_tdata == '0);
                    state_next = (s_tdata == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                // The divider starts in the cycle after the item is taken.
                div_start = launch_reg;
                if (zero_reg) begin
                    state_next = ST_OUT;
                end else if (div_done) begin
                    srch_start = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (srch_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (zero_reg) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {4'd0, srch_word, srch_presc, srch_stat.hit};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            zero_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            clk_hz_reg   <= 32'd48000000;
            launch_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            zero_reg     <= zero_next;
            m_tvalid_reg <= m_tvalid_next;
            launch_reg   <= accept && (s_tdata != '0);
            if (cfg_valid && cfg_ready) begin
                clk_hz_reg <= cfg_data;
            end
        end
        m_tdata_reg <= m_tdata_next;
        if (accept) begin
            baud_reg <= s_tdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/cbts_divider.sv -----
// ---------------------------------------------------------------------------
// CAN bit timing search - iterative divider
// Restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cbts_divider
    import cbts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ClockW-1:0] dividend,
    input  wire logic [BaudW-1:0]  divisor,
    output logic                   done,
    output logic [ClockW-1:0]      quotient
);

    logic [ClockW-1:0] quot_reg, quot_next;
    logic [ClockW-1:0] rem_reg,  rem_next;
    logic [BaudW-1:0]  dvs_reg,  dvs_next;
    logic [4:0]        cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ClockW:0]   trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial     = {rem_reg, quot_reg[ClockW-1]} - {1'b0, dvs_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[ClockW]) begin
                rem_next = trial[ClockW-1:0];
            end else begin
                rem_next = {rem_reg[ClockW-2:0], quot_reg[ClockW-1]};
            end
            quot_next = {quot_reg[ClockW-2:0], ~trial[ClockW]};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // The busy and done flags are reset; the counter and the datapath are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/cbts_search.sv -----
// ---------------------------------------------------------------------------
// CAN bit timing search - candidate walker
// Steps through divider, quanta and segment counts one candidate per cycle,
// keeping the product by running additions, and compares it to clocks/bit.
// ---------------------------------------------------------------------------
`default_nettype none

module cbts_search
    import cbts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [ClockW-1:0] cpb,
    output search_stat_t           stat,
    output logic [PrescW-1:0]      prescaler,
    output logic [WordW-1:0]       bit_timing_word
);

    logic [ClockW-1:0] cpb_reg,  cpb_next;
    logic [3:0]        d_reg,    d_next;     // divider - 1
    logic [4:0]        q_reg,    q_next;     // quanta - 1
    logic [3:0]        s_reg,    s_next;     // segments - 3
    logic [4:0]        dp1_reg,  dp1_next;   // divider
    logic [9:0]        qd_reg,   qd_next;    // quanta * divider
    logic [13:0]       prod_reg, prod_next;  // segments * quanta * divider
    logic              busy_reg, busy_next;
    logic              hit_reg,  hit_next;
    logic              done_reg, done_next;
    logic              match;
    logic [9:0]        qd_step;
    logic [4:0]        dp1_step;

    // Three times a ten-bit value, as shift and add.
    function automatic logic [13:0] times3(input logic [9:0] v);
        return {3'd0, v, 1'b0} + {4'd0, v};
    endfunction

    assign match    = (cpb_reg == {18'd0, prod_reg});
    assign qd_step  = qd_reg + {5'd0, dp1_reg};
    assign dp1_step = dp1_reg + 5'd1;

    // Walk order: segments innermost, then quanta, then divider.
    always_comb begin
        cpb_next  = cpb_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        s_next    = s_reg;
        dp1_next  = dp1_reg;
        qd_next   = qd_reg;
        prod_next = prod_reg;
        busy_next = busy_reg;
        hit_next  = hit_reg;
        done_next = 1'b0;
        if (start) begin
            cpb_next  = cpb;
            d_next    = '0;
            q_next    = '0;
            s_next    = '0;
            dp1_next  = 5'd1;
            qd_next   = 10'd1;
            prod_next = 14'd3;
            busy_next = 1'b1;
            hit_next  = 1'b0;
        end else if (busy_reg) begin
            if (match) begin
                busy_next = 1'b0;
                hit_next  = 1'b1;
                done_next = 1'b1;
            end else if (d_reg == DivLast && q_reg == QuantaLast && s_reg == SegsLast) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (s_reg != SegsLast) begin
                s_next    = s_reg + 4'd1;
                prod_next = prod_reg + {4'd0, qd_reg};
            end else if (q_reg != QuantaLast) begin
                s_next    = '0;
                q_next    = q_reg + 5'd1;
                qd_next   = qd_step;
                prod_next = times3(qd_step);
            end else begin
                s_next    = '0;
                q_next    = '0;
                d_next    = d_reg + 4'd1;
                dp1_next  = dp1_step;
                qd_next   = {5'd0, dp1_step};
                prod_next = times3({5'd0, dp1_step});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            done_reg <= done_next;
        end
        cpb_reg  <= cpb_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        dp1_reg  <= dp1_next;
        qd_reg   <= qd_next;
        prod_reg <= prod_next;
    end

    // Result fields are zero unless the walk ended on a hit.
    assign stat.done       = done_reg;
    assign stat.hit        = hit_reg;
    assign prescaler       = hit_reg ? d_reg : '0;
    assign bit_timing_word = hit_reg ? pack_timing(q_reg, s_reg) : '0;

endmodule

`default_nettype wire

// ----- rtl/cbts_checker.sv -----
// ---------------------------------------------------------------------------
// CAN bit timing search - port checker
// Watches the top level's ports and checks item flow and result fields.
// ---------------------------------------------------------------------------
`default_nettype none

module cbts_checker
    import cbts_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OutDataW-1:0] m_tdata
);

    // A taken item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an item was taken");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // A miss carries all-zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[OutDataW-1:1] == '0)
        else $error("miss result with nonzero fields");

    // On a hit, time segment 2 equals time segment 1 or one more.
    a_seg_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            ({1'b0, m_tdata[19:17]} == m_tdata[16:13]) ||
            ({1'b0, m_tdata[19:17]} == m_tdata[16:13] + 4'd1))
        else $error("segment split out of balance");

    // A result appears only after the block was busy.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work in progress");

endmodule

bind can_bit_timing_search_top cbts_checker u_cbts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
